// ===== hw/rtl/dra_pkg.sv =====
// Shared types for the detection report aggregator: channel payloads,
// the stored table entry, and the controller/datapath command and status groups.
// No dependencies.
package dra_pkg;

   typedef struct packed {
      logic               command;
      logic [15:0]        target_id;
      logic [31:0]        emission_tag;
      logic signed [15:0] sn_db;
   } req_type;

   typedef struct packed {
      logic [15:0]        target_id_out;
      logic [31:0]        emission_tag_out;
      logic signed [15:0] best_sn_db;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        target;
      logic [31:0]        emission;
      logic signed [15:0] best_sn;
   } entry_type;

   localparam int unsigned EntryWidth = $bits(entry_type);

   // Input command codes
   localparam logic CMD_DETECTION   = 1'b0;
   localparam logic CMD_END_OF_SCAN = 1'b1;

   // Controller to datapath
   typedef struct packed {
      logic load_item;    // capture the accepted input transfer
      logic clear_idx;    // restart the table walk at entry 0
      logic search_step;  // issue a read for the next entry under search
      logic write_entry;  // write the held item (update on hit, append on miss)
      logic emit_load;    // load the output register from the read entry
      logic advance;      // step the walk index during emission
      logic clear_count;  // empty the table
   } dra_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic count_zero;
      logic hit;          // entry checked this cycle matches the held target
      logic greater;      // held ratio strictly above the stored one
      logic miss_done;    // every entry checked, none matched
      logic full;
      logic emit_last;    // walk index points at the final stored entry
      logic out_free;     // output register empty or being taken
   } dra_sts_type;

endpackage

// ===== hw/rtl/detection_report_aggregator_unit.sv =====
// Detection report aggregator: keeps one radar scan's detections in a table
// of up to TABLE_DEPTH entries keyed by target id, keeping per target the
// emission tag with the strictly largest signed ratio, and at end of scan
// streams every entry in table order with last set on the final one, then
// empties the table. Items are handled one at a time. A detection compares
// against the stored entries in turn until it finds a match (at most
// TABLE_DEPTH): the table sits in one RAM with a single registered
// read port, so the search reads one entry per cycle. An end-of-scan item
// reads and then loads each emitted entry in turn, waiting while the
// result side stalls; an end-of-scan with an empty table, or any item while
// track_manager_present is 0, is finished on acceptance without leaving idle.
// Register 0 at byte address 0 (bit 0) is track_manager_present, reset 1;
// with it clear detections are dropped and end of scan empties the table
// silently. Write it only while the block is idle. Depends on dra_pkg,
// dra_controller, dra_datapath, dra_ram.
module detection_report_aggregator_unit #(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   // Input channel
   input  logic              req_valid,
   output logic              req_stall,
   input  dra_pkg::req_type  req_payload,
   // Result channel
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dra_pkg::rsp_type  rsp_payload,
   // Configuration port
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);
   import dra_pkg::*;

   dra_cmd_type cmd;
   dra_sts_type sts;
   logic        track_manager_present_ff, track_manager_present_in;
   logic        csr_write;

   // Register file: one bit; address bit 2 selects the register slot, so
   // any write outside slot 0 is dropped.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && !paddr[2];

   always_comb begin
      track_manager_present_in = track_manager_present_ff;
      if (csr_write) begin
         track_manager_present_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         track_manager_present_ff <= 1'b1;
      end else begin
         track_manager_present_ff <= track_manager_present_in;
      end
   end

   assign prdata = paddr[2] ? 32'd0 : {31'd0, track_manager_present_ff};

   // Sequence each transfer: search/update/append or end-of-scan burst
   dra_controller u_ctrl (
      .clock                 (clock),
      .reset                 (reset),
      .track_manager_present (track_manager_present_ff),
      .req_valid             (req_valid),
      .req_command           (req_payload.command),
      .req_stall             (req_stall),
      .sts                   (sts),
      .cmd                   (cmd)
   );

   // Hold the table, the walk and the output register
   dra_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_payload (req_payload),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

   a_cfg_idle_drop: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && !track_manager_present_ff |=> !req_stall)
      else $error("dropped item held the input side");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("waiting result changed or dropped");

   a_stall_while_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.search_step |-> req_stall)
      else $error("input taken during a table search");

endmodule

// ===== hw/rtl/dra_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module dra_ram #(
   parameter int unsigned WIDTH      = 64,
   parameter int unsigned DEPTH      = 32,
   parameter int unsigned ADDR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/dra_datapath.sv =====
// Datapath of the detection report aggregator: held item, entry table RAM,
// fill count, walk index, compare stage and output register.
// Depends on dra_pkg and dra_ram.
module dra_datapath #(
   parameter int unsigned TABLE_DEPTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dra_pkg::dra_cmd_type cmd,
   output dra_pkg::dra_sts_type sts,
   input  dra_pkg::req_type     req_payload,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output dra_pkg::rsp_type     rsp_payload
);
   import dra_pkg::*;

   localparam int unsigned AddrWidth  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned CountWidth = $clog2(TABLE_DEPTH + 1);
   localparam logic [CountWidth:0] DepthValue = (CountWidth + 1)'(TABLE_DEPTH);

   req_type                item_ff;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [CountWidth-1:0]  idx_ff, idx_in;
   logic [CountWidth-1:0]  chk_idx_ff;
   logic                   chk_ff, chk_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff;
   logic [EntryWidth-1:0]  rd_data;
   entry_type              rd_entry;
   entry_type              wr_entry;
   logic [AddrWidth-1:0]   wr_addr;
   logic                   issue;
   logic                   chk_is_last;

   assign issue    = idx_ff < count_ff;
   assign rd_entry = entry_type'(rd_data);

   assign wr_entry.target   = item_ff.target_id;
   assign wr_entry.emission = item_ff.emission_tag;
   assign wr_entry.best_sn  = item_ff.sn_db;
   // On a hit rewrite the matching slot, otherwise append at the fill count
   assign wr_addr = sts.hit ? chk_idx_ff[AddrWidth-1:0] : count_ff[AddrWidth-1:0];

   dra_ram #(
      .WIDTH (EntryWidth),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (cmd.write_entry),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (idx_ff[AddrWidth-1:0]),
      .rd_data (rd_data)
   );

   assign chk_is_last = ({1'b0, chk_idx_ff} + (CountWidth + 1)'(1)) == {1'b0, count_ff};

   always_comb begin
      sts.count_zero = count_ff == '0;
      sts.hit        = chk_ff && (rd_entry.target == item_ff.target_id);
      sts.greater    = $signed(item_ff.sn_db) > $signed(rd_entry.best_sn);
      sts.miss_done  = sts.count_zero || (chk_ff && !sts.hit && chk_is_last);
      sts.full       = {1'b0, count_ff} >= DepthValue;
      sts.emit_last  = ({1'b0, idx_ff} + (CountWidth + 1)'(1)) == {1'b0, count_ff};
      sts.out_free   = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.write_entry && !sts.hit) begin
         count_in = count_ff + CountWidth'(1);
      end

      idx_in = idx_ff;
      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if ((cmd.search_step && issue) || cmd.advance) begin
         idx_in = idx_ff + CountWidth'(1);
      end

      chk_in = cmd.search_step && issue;

      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.emit_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         idx_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_payload;
      end
      chk_idx_ff <= idx_ff;
      if (cmd.emit_load) begin
         rsp_ff.target_id_out    <= rd_entry.target;
         rsp_ff.emission_tag_out <= rd_entry.emission;
         rsp_ff.best_sn_db       <= rd_entry.best_sn;
         rsp_ff.last             <= sts.emit_last;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, count_ff} <= DepthValue)
      else $error("fill count beyond table depth");

   a_append_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry && !sts.hit && !cmd.clear_count |=> count_ff == $past(count_ff) + CountWidth'(1))
      else $error("append did not grow the table");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> sts.out_free)
      else $error("output register overwritten while a result waits");

   a_last_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load && sts.emit_last |=> count_ff == '0)
      else $error("table not emptied after final result");

endmodule

// ===== hw/rtl/dra_controller.sv =====
// Controller state machine of the detection report aggregator: sequences the
// table search, update/append and the end-of-scan emission.
// Depends on dra_pkg.
module dra_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 track_manager_present,
   input  logic                 req_valid,
   input  logic                 req_command,
   output logic                 req_stall,
   input  dra_pkg::dra_sts_type sts,
   output dra_pkg::dra_cmd_type cmd
);
   import dra_pkg::*;

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_SEARCH    = 2'd1;
   localparam logic [1:0] ST_EMIT_READ = 2'd2;
   localparam logic [1:0] ST_EMIT_LOAD = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_stall = state_ff != ST_IDLE;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               cmd.clear_idx = 1'b1;
               if (req_command == CMD_END_OF_SCAN) begin
                  if (track_manager_present && !sts.count_zero) begin
                     state_in = ST_EMIT_READ;
                  end else begin
                     cmd.clear_count = 1'b1;
                  end
               end else if (track_manager_present) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            priority if (sts.hit) begin
               cmd.write_entry = sts.greater;
               state_in        = ST_IDLE;
            end else if (sts.miss_done) begin
               cmd.write_entry = !sts.full;
               state_in        = ST_IDLE;
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         ST_EMIT_READ: begin
            state_in = ST_EMIT_LOAD;
         end
         ST_EMIT_LOAD: begin
            if (sts.out_free) begin
               cmd.emit_load = 1'b1;
               cmd.advance   = 1'b1;
               if (sts.emit_last) begin
                  cmd.clear_count = 1'b1;
                  state_in        = ST_IDLE;
               end else begin
                  state_in = ST_EMIT_READ;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_write_only_search: assert property (@(posedge clock) disable iff (reset)
      cmd.write_entry |-> state_ff == ST_SEARCH)
      else $error("table written outside a search");

   a_emit_needs_read: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_load |-> $past(state_ff) == ST_EMIT_READ || $past(state_ff) == ST_EMIT_LOAD)
      else $error("result loaded before its table read completed");

   a_search_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SEARCH && (sts.hit || sts.miss_done) |=> state_ff == ST_IDLE)
      else $error("search did not finish on its decision");

endmodule

// ===== tb/detection_report_aggregator_unit_tb.sv =====
// Self-checking testbench for detection_report_aggregator_unit: drives scans of
// detections and end-of-scan items, predicts the emitted reports, checks them.
// Depends on dra_pkg and the detection_report_aggregator_unit RTL.
module detection_report_aggregator_unit_tb;

   localparam int unsigned TABLE_DEPTH = 32;
   // Settle time after the queues drain: covers a search over a full table.
   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 300;

   // Register byte addresses: one real register, and one slot past the list.
   localparam logic [2:0] CSR_TRACK_MANAGER = 3'd0;
   localparam logic [2:0] CSR_UNMAPPED = 3'd4;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_mode_type;

   // One queued input transfer; hold_for_drain makes the sender wait until
   // every outstanding report has been taken before offering it.
   typedef struct {
      dra_pkg::req_type item;
      bit               hold_for_drain;
   } scan_item_type;

   logic             clock;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   dra_pkg::req_type req_payload = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   dra_pkg::rsp_type rsp_payload;
   logic             psel = 1'b0;
   logic             penable = 1'b0;
   logic             pwrite = 1'b0;
   logic [2:0]       paddr = '0;
   logic [31:0]      pwdata = '0;
   logic [31:0]      prdata;
   logic             pready;

   // Predicted table of the current scan and the register copy.
   dra_pkg::entry_type scan_table [TABLE_DEPTH];
   int                 scan_fill = 0;
   bit                 consumer_present = 1'b1;

   scan_item_type      scan_items [$];
   dra_pkg::rsp_type   expected_reports [$];
   bit                 drain_next = 1'b0;

   int             error_count = 0;
   int             idle_cycles = 0;
   int             burst_left = 0;
   int             gap_left = 0;
   stall_mode_type stall_mode = STALL_NONE;
   int             stall_span = 0;

   detection_report_aggregator_unit #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Advance the predicted scan table by one accepted transfer. End of scan
   // queues one report per stored entry (none without a consumer) and empties
   // the table; with a consumer present, a detection updates on the first match
   // only when its ratio is strictly greater, else appends while there is room.
   function automatic void update_scan_table(input dra_pkg::req_type item);
      dra_pkg::rsp_type report;
      int               idx;
      bit               matched;
      matched = 1'b0;
      if (item.command == dra_pkg::CMD_END_OF_SCAN) begin
         if (consumer_present) begin
            for (idx = 0; idx < scan_fill; idx++) begin
               report.target_id_out    = scan_table[idx].target;
               report.emission_tag_out = scan_table[idx].emission;
               report.best_sn_db       = scan_table[idx].best_sn;
               report.last             = (idx == scan_fill - 1);
               expected_reports.push_back(report);
            end
         end
         scan_fill = 0;
      end else if (consumer_present) begin
         for (idx = 0; idx < scan_fill && !matched; idx++) begin
            if (scan_table[idx].target == item.target_id) begin
               matched = 1'b1;
               if ($signed(item.sn_db) > $signed(scan_table[idx].best_sn)) begin
                  scan_table[idx].emission = item.emission_tag;
                  scan_table[idx].best_sn  = item.sn_db;
               end
            end
         end
         if (!matched && scan_fill < TABLE_DEPTH) begin
            scan_table[scan_fill].target   = item.target_id;
            scan_table[scan_fill].emission = item.emission_tag;
            scan_table[scan_fill].best_sn  = item.sn_db;
            scan_fill++;
         end
      end
   endfunction

   function automatic void add_item(input logic cmd, input logic [15:0] tid,
                                    input logic [31:0] tag,
                                    input logic signed [15:0] sn);
      scan_item_type entry;
      entry.item.command      = cmd;
      entry.item.target_id    = tid;
      entry.item.emission_tag = tag;
      entry.item.sn_db        = sn;
      entry.hold_for_drain    = drain_next;
      drain_next = 1'b0;
      scan_items.push_back(entry);
   endfunction

   // Favor the ratio extremes and small values so that equal ratios recur.
   function automatic logic signed [15:0] random_ratio();
      case ($urandom_range(0, 7))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'sh0000;
         3: return 16'shFFFF;
         4: return 16'($urandom_range(0, 3));
         default: return 16'($urandom);
      endcase
   endfunction

   // Queue one scan of random shape and return how many transfers it holds.
   // Most scans are well formed; some overflow the table, some are noise of
   // random commands, and some stop without an end of scan.
   function automatic int build_scan();
      logic [15:0] target_pool [$];
      logic [15:0] base;
      int          kind;
      int          pool_size;
      int          count;
      int          idx;
      kind = $urandom_range(0, 19);
      base = 16'($urandom);
      if (kind == 1) begin
         count = $urandom_range(1, 4);
         for (idx = 0; idx < count; idx++) begin
            add_item(1'($urandom_range(0, 1)), 16'($urandom), $urandom, random_ratio());
         end
         return count;
      end
      if (kind == 0) begin
         // Distinct targets beyond the table size: the tail is dropped.
         pool_size = $urandom_range(TABLE_DEPTH + 1, TABLE_DEPTH + 8);
         for (idx = 0; idx < pool_size; idx++) begin
            target_pool.push_back(base + 16'(idx));
            add_item(dra_pkg::CMD_DETECTION, target_pool[idx], $urandom, random_ratio());
         end
         count = pool_size;
      end else begin
         pool_size = $urandom_range(1, 8);
         for (idx = 0; idx < pool_size; idx++) begin
            target_pool.push_back(16'($urandom));
         end
         count = 0;
      end
      // Revisit pooled targets to exercise matching and ratio updates.
      for (idx = 0; idx < $urandom_range(1, 12); idx++) begin
         add_item(dra_pkg::CMD_DETECTION, target_pool[$urandom_range(0, pool_size - 1)],
                  $urandom, random_ratio());
         count++;
      end
      if (kind != 2) begin
         add_item(dra_pkg::CMD_END_OF_SCAN, 16'($urandom), $urandom, 16'($urandom));
         count++;
         if ($urandom_range(0, 5) == 0) begin
            drain_next = 1'b1;
         end
      end
      return count;
   endfunction

   // Wait until every queued transfer is accepted and every report has come,
   // then let a search still in flight finish.
   task automatic wait_idle();
      do @(negedge clock);
      while (scan_items.size() != 0 || req_valid || expected_reports.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the data at the edge
   // that completes the access.
   task automatic write_csr(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      if (addr == CSR_TRACK_MANAGER) begin
         consumer_present = data[0];
      end
   endtask

   task automatic check_csr(input logic [2:0] addr, input logic want_bit);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= addr;
      @(posedge clock);
      penable <= 1'b1;
      // Sample mid-cycle, while the access phase is stable.
      do @(negedge clock);
      while (!pready);
      if (prdata[0] !== want_bit) begin
         $error("track_manager_present: expected %0b, actual %0b", want_bit, prdata[0]);
         error_count++;
      end
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // Sender: offer queued items in bursts of random length with random gaps.
   // Hold valid and payload until the transfer completes; predict on accept.
   always @(posedge clock) begin : req_driver
      scan_item_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            update_scan_table(req_payload);
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (scan_items.size() != 0 &&
                         !(scan_items[0].hold_for_drain && expected_reports.size() != 0)) begin
               next_item = scan_items.pop_front();
               req_valid   <= 1'b1;
               req_payload <= next_item.item;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 12);
                  case ($urandom_range(0, 7))
                     0, 1, 2: gap_left = 0;
                     3, 4, 5: gap_left = $urandom_range(1, 4);
                     6: gap_left = $urandom_range(5, 20);
                     default: gap_left = $urandom_range(30, 60);
                  endcase
               end else begin
                  burst_left--;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall on a pattern whose mode is redrawn at random, including
   // stretches with no stall at all.
   always @(posedge clock) begin : rsp_stall_pattern
      if (stall_span == 0) begin
         stall_mode = stall_mode_type'($urandom_range(0, 3));
         stall_span = $urandom_range(16, 160);
      end else begin
         stall_span--;
      end
      case (stall_mode)
         STALL_NONE:  rsp_stall <= 1'b0;
         STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
         STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
         default:     rsp_stall <= ~rsp_stall;
      endcase
   end

   // Check every report transfer against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      dra_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_reports.size() == 0) begin
            $error("unexpected report: target_id_out %h", rsp_payload.target_id_out);
            error_count++;
         end else begin
            want = expected_reports.pop_front();
            if (rsp_payload.target_id_out !== want.target_id_out) begin
               $error("target_id_out: expected %h, actual %h",
                      want.target_id_out, rsp_payload.target_id_out);
               error_count++;
            end
            if (rsp_payload.emission_tag_out !== want.emission_tag_out) begin
               $error("emission_tag_out: expected %h, actual %h",
                      want.emission_tag_out, rsp_payload.emission_tag_out);
               error_count++;
            end
            if (rsp_payload.best_sn_db !== want.best_sn_db) begin
               $error("best_sn_db: expected %0d, actual %0d",
                      want.best_sn_db, rsp_payload.best_sn_db);
               error_count++;
            end
            if (rsp_payload.last !== want.last) begin
               $error("last: expected %0b, actual %0b", want.last, rsp_payload.last);
               error_count++;
            end
         end
      end
   end

   // Watchdog: end the run when no transfer moves on either channel for too long.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int  counted;
      int  added;
      int  phase;
      bit  setting;
      counted = 0;
      phase = 0;
      wait (!reset);
      check_csr(CSR_TRACK_MANAGER, 1'b1);

      // Ratio extremes and ties: equal ratio keeps the stored entry, a
      // strictly greater one replaces tag and ratio, a lower one is ignored.
      add_item(dra_pkg::CMD_DETECTION, 16'h0000, 32'h0000_0000, 16'sh8000);
      add_item(dra_pkg::CMD_DETECTION, 16'h0000, 32'hFFFF_FFFF, 16'sh8000);
      add_item(dra_pkg::CMD_DETECTION, 16'h0000, 32'h1357_9BDF, 16'sh8001);
      add_item(dra_pkg::CMD_DETECTION, 16'hFFFF, 32'hFFFF_FFFF, 16'sh7FFF);
      add_item(dra_pkg::CMD_DETECTION, 16'hFFFF, 32'h0000_0000, 16'sh7FFF);
      add_item(dra_pkg::CMD_DETECTION, 16'hFFFF, 32'h2468_ACE0, 16'sh0000);
      add_item(dra_pkg::CMD_DETECTION, 16'h5555, 32'hAAAA_AAAA, 16'sh5555);
      add_item(dra_pkg::CMD_DETECTION, 16'hAAAA, 32'h5555_5555, 16'shAAAA);
      add_item(dra_pkg::CMD_DETECTION, 16'h5555, 32'h5555_5555, 16'sh7FFF);
      add_item(dra_pkg::CMD_END_OF_SCAN, 16'hFFFF, 32'hFFFF_FFFF, 16'shFFFF);
      // Empty table at end of scan; hold it until the burst above has drained.
      drain_next = 1'b1;
      add_item(dra_pkg::CMD_END_OF_SCAN, 16'h0000, 32'h0000_0000, 16'sh0000);
      wait_idle();

      // A write past the register list must leave the consumer enabled.
      write_csr(CSR_UNMAPPED, 32'h0000_0000);
      check_csr(CSR_TRACK_MANAGER, 1'b1);
      add_item(dra_pkg::CMD_DETECTION, 16'h0F0F, 32'hF0F0_F0F0, 16'shFFFF);
      wait_idle();

      // No consumer: drop the detection, empty the table silently.
      write_csr(CSR_TRACK_MANAGER, 32'hFFFF_FFFE);
      check_csr(CSR_TRACK_MANAGER, 1'b0);
      add_item(dra_pkg::CMD_DETECTION, 16'h00FF, 32'h0F0F_0F0F, 16'sh0001);
      add_item(dra_pkg::CMD_END_OF_SCAN, 16'h00FF, 32'h0000_0000, 16'sh0000);
      wait_idle();

      // Consumer back: the table must be empty, then a single-entry scan.
      write_csr(CSR_TRACK_MANAGER, 32'h0000_0001);
      check_csr(CSR_TRACK_MANAGER, 1'b1);
      add_item(dra_pkg::CMD_END_OF_SCAN, 16'h1234, 32'h0000_0000, 16'sh0000);
      add_item(dra_pkg::CMD_DETECTION, 16'h00FF, 32'hC3C3_3C3C, 16'sh0001);
      add_item(dra_pkg::CMD_END_OF_SCAN, 16'h0000, 32'h0000_0000, 16'sh0000);
      wait_idle();

      // Random phases; every fourth one runs without a consumer and is kept
      // short since the block drops its detections.
      while (counted < RANDOM_ITEMS) begin
         setting = (phase % 4 != 2);
         write_csr(CSR_TRACK_MANAGER, ($urandom & 32'hFFFF_FFFE) | 32'(setting));
         check_csr(CSR_TRACK_MANAGER, setting);
         added = 0;
         while (added < (setting ? 60 : 12)) begin
            added += build_scan();
         end
         counted += added;
         wait_idle();
         phase++;
      end

      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
hw/rtl/dra_pkg.sv
hw/rtl/dra_ram.sv
hw/rtl/dra_datapath.sv
hw/rtl/dra_controller.sv
hw/rtl/detection_report_aggregator_unit.sv
tb/detection_report_aggregator_unit_tb.sv
